// ===== rtl/core/rgle_pkg.sv =====
// Shared types, constants and helpers for the RGB-to-grey Laplacian edge filter.
// No dependencies; the scan, kernel and top-level files import this package.
package rgle_pkg;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

  // Frame geometry limits and reset values
  localparam int unsigned MIN_DIM       = 3;
  localparam int unsigned MAX_HEIGHT    = 4096;
  localparam int unsigned RESET_WIDTH   = 640;
  localparam int unsigned RESET_HEIGHT  = 480;

  // Luma weights, scaled by 2^GREY_SHIFT
  localparam logic [9:0]  COEF_R     = 10'd307;
  localparam logic [9:0]  COEF_G     = 10'd604;
  localparam logic [9:0]  COEF_B     = 10'd113;
  localparam int unsigned GREY_SHIFT = 10;

  localparam logic [7:0]  PIX_MAX    = 8'd255;

  // One pixel on its way from the scan stage to the kernel stage
  typedef struct packed {
    logic [7:0]  grey;
    logic        emit;        // window centre is interior: produce a word
    logic [11:0] dest_row;
    logic [10:0] dest_col;
    logic        frame_done;
  } rgle_item_t;

  function automatic logic [7:0] grey_of(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
    logic [17:0] acc;
    acc = 18'(COEF_R) * 18'(r) + 18'(COEF_G) * 18'(g) + 18'(COEF_B) * 18'(b);
    return 8'(acc >> GREY_SHIFT);
  endfunction

endpackage

// ===== rtl/core/rgle_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No package dependency.
module rgle_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/rgle_scan.sv =====
// Scan stage: geometry registers, raster position counters, grey conversion
// and the stage register feeding the kernel. Depends on rgle_pkg.
module rgle_scan #(
  parameter int unsigned MAX_WIDTH = 2048,
  parameter int unsigned CW        = $clog2(MAX_WIDTH)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [rgle_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rgle_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           accept_i,
  input  logic                           block_i,
  input  logic [7:0]                     red_i,
  input  logic [7:0]                     green_i,
  input  logic [7:0]                     blue_i,
  output logic [CW-1:0]                  rd_addr_o,
  output logic                           s1_valid_o,
  output logic [CW-1:0]                  s1_addr_o,
  output rgle_pkg::rgle_item_t           s1_item_o
);
  import rgle_pkg::*;

  localparam int unsigned RST_W = (RESET_WIDTH < MAX_WIDTH) ? RESET_WIDTH : MAX_WIDTH;
  localparam logic [CW-1:0] RST_COL_LAST = CW'(RST_W - 1);

  logic [CW-1:0] col_last_q, col_last_d;
  logic [11:0]   row_last_q, row_last_d;
  logic [12:0]   height_q, height_d;
  logic [CW-1:0] col_q, col_d;
  logic [11:0]   row_q, row_d;
  logic          s1_valid_q, s1_valid_d;
  logic [CW-1:0] s1_addr_q;
  rgle_item_t    s1_item_q, item_d;

  logic [11:0]   w_raw;
  logic [13:0]   w_clamp;
  logic [12:0]   h_raw;
  logic [13:0]   h_clamp;
  logic          col_end, row_end;
  logic [CW-1:0] col_m1;

  // Clamp written geometry once, at write time
  always_comb begin
    w_raw = cfg_data_i[11:0];
    h_raw = cfg_data_i[12:0];
    if (14'(w_raw) < 14'(MIN_DIM)) begin
      w_clamp = 14'(MIN_DIM);
    end else if (14'(w_raw) > 14'(MAX_WIDTH)) begin
      w_clamp = 14'(MAX_WIDTH);
    end else begin
      w_clamp = 14'(w_raw);
    end
    if (14'(h_raw) < 14'(MIN_DIM)) begin
      h_clamp = 14'(MIN_DIM);
    end else if (14'(h_raw) > 14'(MAX_HEIGHT)) begin
      h_clamp = 14'(MAX_HEIGHT);
    end else begin
      h_clamp = 14'(h_raw);
    end
  end

  always_comb begin
    col_last_d = col_last_q;
    row_last_d = row_last_q;
    height_d   = height_q;
    if (cfg_valid_i && cfg_index_i == REG_WIDTH) begin
      col_last_d = CW'(w_clamp - 14'd1);
    end
    if (cfg_valid_i && cfg_index_i == REG_HEIGHT) begin
      height_d   = 13'(h_clamp);
      row_last_d = 12'(h_clamp - 14'd1);
    end
  end

  assign col_end = (col_q == col_last_q);
  assign row_end = (row_q == row_last_q);
  assign col_m1  = col_q - CW'(1);

  // Advance the raster position; a write to the width or height register restarts the frame
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_valid_i && (cfg_index_i == REG_WIDTH || cfg_index_i == REG_HEIGHT)) begin
      col_d = '0;
      row_d = '0;
    end else if (accept_i) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? 12'd0 : row_q + 12'd1;
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_comb begin
    item_d.grey       = grey_of(red_i, green_i, blue_i);
    item_d.emit       = (row_q >= 12'd2) && (col_q >= CW'(2));
    item_d.dest_row   = 12'(height_q - {1'b0, row_q});
    item_d.dest_col   = 11'(col_m1);
    item_d.frame_done = row_end && col_end;
    s1_valid_d        = block_i ? s1_valid_q : accept_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_last_q <= RST_COL_LAST;
      row_last_q <= 12'(RESET_HEIGHT - 1);
      height_q   <= 13'(RESET_HEIGHT);
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      col_last_q <= col_last_d;
      row_last_q <= row_last_d;
      height_q   <= height_d;
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_item_q <= item_d;
      s1_addr_q <= col_q;
    end
  end

  assign rd_addr_o  = col_q;
  assign s1_valid_o = s1_valid_q;
  assign s1_addr_o  = s1_addr_q;
  assign s1_item_o  = s1_item_q;

  a_col_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= col_last_q)
    else $error("column counter ran past end of line");

  a_row_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= row_last_q)
    else $error("row counter ran past end of frame");

  a_emit_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_item_q.emit) |-> (s1_addr_q >= CW'(2)))
    else $error("result flagged for a border column");

endmodule

// ===== rtl/core/rgle_kernel.sv =====
// Kernel stage: 3x3 grey window, 8-neighbour Laplacian, clamp and output register.
// Depends on rgle_pkg.
module rgle_kernel (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s1_valid_i,
  input  rgle_pkg::rgle_item_t s1_item_i,
  input  logic [15:0]          line_rdata_i,
  input  logic                 out_stall_i,
  output logic                 block_o,
  output logic                 fire_o,
  output logic [15:0]          line_wdata_o,
  output logic                 out_valid_o,
  output logic [7:0]           edge_level_o,
  output logic [11:0]          dest_row_o,
  output logic [10:0]          dest_column_o,
  output logic                 frame_done_o
);
  import rgle_pkg::*;

  // win_q[0..2]: column c-2 (upper, lower, current); win_q[3..5]: column c-1
  logic [5:0][7:0]    win_q, win_d;
  logic [7:0]         up, lo;
  logic [10:0]        neigh_sum;
  logic signed [11:0] diff;
  logic [7:0]         level;
  logic               fire;
  logic               out_valid_q, out_valid_d;
  logic [7:0]         level_q;
  logic [11:0]        row_q;
  logic [10:0]        col_q;
  logic               done_q;

  assign up = line_rdata_i[15:8];
  assign lo = line_rdata_i[7:0];

  // Hold the stage while a result has nowhere to go
  assign block_o = s1_valid_i && s1_item_i.emit && out_valid_q && out_stall_i;
  assign fire    = s1_valid_i && !block_o;
  assign fire_o  = fire;

  // Upper line takes the old lower value, lower line takes the new pixel
  assign line_wdata_o = {lo, s1_item_i.grey};

  always_comb begin
    neigh_sum = 11'(win_q[0]) + 11'(win_q[1]) + 11'(win_q[2]) + 11'(win_q[3])
              + 11'(win_q[5]) + 11'(up) + 11'(lo) + 11'(s1_item_i.grey);
    diff      = $signed({1'b0, win_q[4], 3'b000}) - $signed({1'b0, neigh_sum});
    if (diff < 12'sd0) begin
      level = '0;
    end else if (diff > $signed({4'b0, PIX_MAX})) begin
      level = PIX_MAX;
    end else begin
      level = diff[7:0];
    end
  end

  always_comb begin
    win_d = win_q;
    if (fire) begin
      win_d[0] = win_q[3];
      win_d[1] = win_q[4];
      win_d[2] = win_q[5];
      win_d[3] = up;
      win_d[4] = lo;
      win_d[5] = s1_item_i.grey;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire && s1_item_i.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      win_q       <= win_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && s1_item_i.emit) begin
      level_q <= level;
      row_q   <= s1_item_i.dest_row;
      col_q   <= s1_item_i.dest_col;
      done_q  <= s1_item_i.frame_done;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign edge_level_o  = level_q;
  assign dest_row_o    = row_q;
  assign dest_column_o = col_q;
  assign frame_done_o  = done_q;

  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && s1_item_i.emit) |=> out_valid_q)
    else $error("fired result did not reach the output register");

  a_window_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(win_q))
    else $error("window moved without a pixel leaving the kernel stage");

endmodule

// ===== rtl/core/rgb_grey_laplacian_edge_filter.sv =====
// Top level of the RGB-to-grey 3x3 Laplacian edge filter.
// Depends on rgle_pkg, rgle_ram, rgle_scan and rgle_kernel.
//
// Feed RGB pixels in raster order on the input channel (in_valid_i / in_stall_o,
// red_i, green_i, blue_i). For every pixel whose 3x3 neighborhood is complete the
// block emits one word on the output channel (out_valid_o / out_stall_i): the
// clamped 8-neighbor Laplacian of the window centre, its flipped row, its column,
// and frame_done on the last interior pixel of a frame. Border pixels give no word.
// The configuration channel (cfg_valid_i, cfg_ready_o always high, cfg_index_i,
// cfg_data_i) sets line width (index 0) and frame height (index 1); either write
// restarts the frame at row 0, column 0. Write only while the block is idle.
// One pixel per clock sustained while in_stall_o is low. An accepted pixel and its
// line-store read are registered into the kernel stage; window and Laplacian go
// into the output register as it leaves. The line RAM is read at the accept and
// written at the same column when that pixel leaves the kernel stage, never the
// same entry in one cycle. Reset clears position, window and output valid and sets
// 640 x 480; line store contents stay undefined and never reach a word. While the
// receiver stalls, hold the word and keep taking pixels until the next interior
// pixel reaches the kernel stage; then raise in_stall_o until the output drains.
module rgb_grey_laplacian_edge_filter #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rgle_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rgle_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [7:0]                      red_i,
  input  logic [7:0]                      green_i,
  input  logic [7:0]                      blue_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [7:0]                      edge_level_o,
  output logic [11:0]                     dest_row_o,
  output logic [10:0]                     dest_column_o,
  output logic                            frame_done_o
);
  import rgle_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);

  logic          accept;
  logic          block;
  logic          fire;
  logic [CW-1:0] rd_addr;
  logic          s1_valid;
  logic [CW-1:0] s1_addr;
  rgle_item_t    s1_item;
  logic [15:0]   line_rdata;
  logic [15:0]   line_wdata;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = block;
  assign accept      = in_valid_i && !block;

  rgle_scan #(
    .MAX_WIDTH (MAX_WIDTH),
    .CW        (CW)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .block_i     (block),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .rd_addr_o   (rd_addr),
    .s1_valid_o  (s1_valid),
    .s1_addr_o   (s1_addr),
    .s1_item_o   (s1_item)
  );

  // Both line stores share one word per column: {upper, lower}
  rgle_ram #(
    .WIDTH (16),
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (fire),
    .waddr_i (s1_addr),
    .wdata_i (line_wdata),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (line_rdata)
  );

  rgle_kernel u_kernel (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s1_valid_i    (s1_valid),
    .s1_item_i     (s1_item),
    .line_rdata_i  (line_rdata),
    .out_stall_i   (out_stall_i),
    .block_o       (block),
    .fire_o        (fire),
    .line_wdata_o  (line_wdata),
    .out_valid_o   (out_valid_o),
    .edge_level_o  (edge_level_o),
    .dest_row_o    (dest_row_o),
    .dest_column_o (dest_column_o),
    .frame_done_o  (frame_done_o)
  );

  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && accept) |-> (s1_addr != rd_addr))
    else $error("line store read and write hit the same column");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid && out_valid_o && out_stall_i))
    else $error("intake stalled with room downstream");

  a_stage_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    block |=> (s1_valid && $stable(s1_addr)))
    else $error("kernel stage changed while blocked");

endmodule
